[rtl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert an implication whose consequent is checked on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Assert a condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[rtl/cts_pkg.sv]
// Package: payload types, register indexes and policy codes for the scheduler.
package cts_pkg;
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SRT  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_PREEMPT = 2'd1;
  localparam logic [1:0] REG_SLICE   = 2'd2;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  proc_id;
    logic [11:0] burst;
    logic [7:0]  priority_level;
  } in_item_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_id;
    logic        interval_valid;
    logic [3:0]  interval_id;
    logic [15:0] interval_start;
    logic [15:0] interval_end;
    logic        completed;
    logic        admit_rejected;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  ident;
    logic [11:0] remaining;
    logic [7:0]  prio;
  } entry_t;
endpackage

[rtl/cpu_tick_scheduler_unit.sv]
// Top level: tick-driven process scheduler with a sequenced ready table.
//
// Usage: items enter on in_valid/in_ready with an in_item_t payload. An admit
// (mode 0) appends a process to the ready table; a tick (mode 1) advances time,
// charges the running process, then completes, rotates or preempts it. Each
// item yields exactly one out_item_t beat on out_valid/out_ready.
// Configuration registers (policy, preempt enable, time slice) are written on
// cfg_valid/cfg_ready with cfg_index/cfg_data while the block is idle and no
// result waits; a pending write holds in_ready low.
// The path from the accepting edge to out_valid depends on the item: a plain
// or rejected admit or an empty tick goes straight to the result, a plain tick
// first charges the running entry, an admit that reselects or a preempt check
// scans the table, a rotation moves the entries behind the running one, and a
// completion moves them and may then rescan the table. Every table move and every scan
// step goes through the single RAM read port, one entry per cycle.
// One item at a time: in_ready returns the cycle after the result is loaded.
// The result waits in the output register, so a stalled receiver holds the
// block only when the next item finishes before the waiting beat is taken.
// Reset (synchronous, rst high) empties the table, clears time and restores
// the default registers; table contents need no clearing pass.
module cpu_tick_scheduler_unit #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cts_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cts_pkg::out_item_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = $bits(cts_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_TDEC, S_TACT, S_MVR, S_MVW, S_POST, S_MVT, S_SKEY, S_SCAN, S_SCANE,
    S_ID, S_DONE
  } state_t;

  state_t state;

  logic [1:0] policy;
  logic       preempt;
  logic [7:0] slice;

  logic [CW-1:0]        count;
  logic [TIME_BITS-1:0] time_now;
  logic [TIME_BITS-1:0] run_start;
  logic [7:0]           quantum;
  logic [AW-1:0]        run_pos;

  // ram port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  cts_pkg::entry_t wdata, rdata;

  cts_ram #(.WIDTH(EW), .DEPTH(MAX_PROCS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // working registers
  cts_pkg::entry_t   cur;       // running entry copy
  logic [AW-1:0]     idx;       // sweep index
  logic [AW-1:0]     mv_last;   // last occupied position before a move
  logic              rotate;    // move puts cur at the end
  logic [AW-1:0]     best_pos;
  logic [11:0]       best_key;
  logic [AW-1:0]     rpos;      // position of the entry now on rdata
  logic              have;      // best_key loaded
  logic              scan_pre;  // scan is a preempt check
  logic              iv, done, rej;
  logic [3:0]        iid;
  logic [TIME_BITS-1:0] ist, iend;

  logic          scan_pol;
  logic [11:0]   rd_key;
  logic          better;
  logic [AW-1:0] scan_pick;
  logic          in_fire;
  logic          admit_ok;
  logic          out_load;

  assign scan_pol  = (policy == cts_pkg::POL_SRT) || (policy == cts_pkg::POL_PRIO);
  assign rd_key    = (policy == cts_pkg::POL_SRT) ? rdata.remaining : {4'd0, rdata.prio};
  assign better    = rd_key < best_key;
  assign scan_pick = better ? rpos : best_pos;

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_fire   = in_valid && in_ready;
  assign admit_ok  = (in_data.mode == cts_pkg::MODE_ADMIT) && (count < CW'(MAX_PROCS));
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    we    = 1'b0;
    waddr = run_pos;
    wdata = cur;
    raddr = run_pos;
    unique case (state)
      S_IDLE: begin
        we    = in_fire && admit_ok;
        waddr = AW'(count);
        wdata = '{ident: in_data.proc_id, remaining: in_data.burst,
                  prio: in_data.priority_level};
      end
      S_TACT: we = 1'b1;
      S_MVR:  raddr = AW'(idx + AW'(1));
      S_MVW: begin
        we    = 1'b1;
        waddr = idx;
        wdata = rdata;
        raddr = AW'(idx + AW'(2));
      end
      S_MVT: begin
        we    = 1'b1;
        waddr = mv_last;
      end
      S_SKEY: raddr = best_pos;
      S_SCAN: raddr = idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      policy    <= cts_pkg::POL_FCFS;
      preempt   <= 1'b0;
      slice     <= 8'd2;
      count     <= '0;
      time_now  <= '0;
      run_start <= '0;
      quantum   <= 8'd2;
      run_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
              cts_pkg::REG_POLICY:  policy  <= cfg_data[1:0];
              cts_pkg::REG_PREEMPT: preempt <= cfg_data[0];
              cts_pkg::REG_SLICE:   slice   <= cfg_data;
              default: ;
            endcase
          end
          if (in_fire) begin
            iv <= 1'b0; done <= 1'b0; iid <= '0; ist <= '0; iend <= '0;
            rej <= (in_data.mode == cts_pkg::MODE_ADMIT) && !admit_ok;
            if (in_data.mode == cts_pkg::MODE_TICK) begin
              time_now <= time_now + TIME_BITS'(1);
              state    <= (count == '0) ? S_ID : S_TDEC;
            end else if (!admit_ok) begin
              state <= S_ID;
            end else begin
              count <= count + CW'(1);
              if (count == '0) begin
                run_pos   <= '0;
                run_start <= time_now;
                quantum   <= slice;
                state     <= S_ID;
              end else if (run_start == time_now && scan_pol) begin
                // reselect among arrivals that share the current tick
                best_pos <= run_pos;
                scan_pre <= 1'b0;
                state    <= S_SKEY;
              end else begin
                state <= S_ID;
              end
            end
          end
        end
        S_TDEC: begin
          // rdata holds the running entry; charge it one tick
          cur <= '{ident: rdata.ident,
                   remaining: (rdata.remaining != '0) ? rdata.remaining - 12'd1 : 12'd0,
                   prio: rdata.prio};
          if (quantum != '0) quantum <= quantum - 8'd1;
          state <= S_TACT;
        end
        S_TACT: begin
          if (cur.remaining == '0 || (policy == cts_pkg::POL_RR && quantum == '0)) begin
            iv <= 1'b1; done <= (cur.remaining == '0); iid <= cur.ident;
            ist <= run_start; iend <= time_now;
            run_start <= time_now; quantum <= slice;
            rotate  <= (cur.remaining != '0);
            idx     <= run_pos;
            mv_last <= AW'(count - CW'(1));
            if (cur.remaining == '0) count <= count - CW'(1);
            state <= (run_pos == AW'(count - CW'(1))) ? S_POST : S_MVR;
          end else if (preempt && scan_pol) begin
            best_pos <= run_pos;
            scan_pre <= 1'b1;
            state    <= S_SKEY;
          end else begin
            state <= S_ID;
          end
        end
        S_MVR: state <= S_MVW;
        S_MVW: begin
          // rdata holds entry idx+1; it lands at idx
          if (AW'(idx + AW'(1)) == mv_last) begin
            state <= S_POST;
          end else begin
            idx <= AW'(idx + AW'(1));
          end
        end
        S_POST: begin
          if (rotate) begin
            state <= S_MVT;
          end else begin
            run_pos <= '0;
            if (count != '0 && scan_pol) begin
              best_pos <= '0;
              scan_pre <= 1'b0;
              state    <= S_SKEY;
            end else begin
              state <= S_ID;
            end
          end
        end
        S_MVT: begin
          run_pos <= '0;
          state   <= S_ID;
        end
        S_SKEY: begin
          idx   <= '0;
          have  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // first cycle sees the initial candidate, later ones entry rpos
          if (!have) begin
            best_key <= rd_key;
          end else if (better) begin
            best_key <= rd_key;
            best_pos <= rpos;
          end
          rpos <= idx;
          have <= 1'b1;
          if (idx == AW'(count - CW'(1))) begin
            state <= S_SCANE;
          end else begin
            idx <= AW'(idx + AW'(1));
          end
        end
        S_SCANE: begin
          run_pos <= scan_pick;
          if (scan_pre && scan_pick != run_pos) begin
            iv <= 1'b1; iid <= cur.ident;
            ist <= run_start; iend <= time_now;
            run_start <= time_now; quantum <= slice;
          end
          state <= S_ID;
        end
        S_ID: state <= S_DONE;
        S_DONE: begin
          // rdata holds the entry at run_pos
          if (out_load) begin
            out_data <= '{running_valid: (count != '0),
                          running_id: (count != '0) ? rdata.ident : 4'd0,
                          interval_valid: iv, interval_id: iid,
                          interval_start: 16'(ist), interval_end: 16'(iend),
                          completed: done, admit_rejected: rej};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count, clk, rst, count <= CW'(MAX_PROCS), "table count overflow")
  `ASSERT_IMPL(a_run_pos, clk, rst, state == S_IDLE && count != '0, CW'(run_pos) < count, "running position outside the table")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `ASSERT_IMPL(a_one_beat, clk, rst, in_valid && in_ready, !(cfg_valid && cfg_ready), "input and config beats together")
endmodule

[rtl/cts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module cts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
